// ===== hdl/hefl_pkg.sv =====
// ----------------------------------------------------------------------------
// hefl_pkg: executable header field lookup, shared types and constants
// Header layout constants, the word types of both channels and the
// configuration register codes.
// ----------------------------------------------------------------------------
`default_nettype none

package hefl_pkg;

  localparam int unsigned MaxEntries    = 256;
  localparam int unsigned CountPos      = 5;
  localparam int unsigned FirstEntryPos = 6;
  localparam int unsigned PosLimit      = FirstEntryPos + 2 * MaxEntries;

  localparam int unsigned PosW = $clog2(PosLimit + 1);
  localparam int unsigned EntW = $clog2(MaxEntries + 1);

  localparam logic [31:0] MagicWord = 32'h5845_5832;
  localparam logic [7:0]  SelValue  = 8'h00;
  localparam logic [7:0]  SelAddr   = 8'h01;

  localparam int unsigned CfgIdxW = 1;

  typedef enum logic [CfgIdxW-1:0] {
    CfgHeaderBase = 1'b0,
    CfgSearchKey  = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    StFound    = 2'd0,
    StAbsent   = 2'd1,
    StBadMagic = 2'd2,
    StNullBase = 2'd3
  } lookup_status_e;

  typedef struct packed {
    logic [31:0] header_word;
    logic        final_word;
  } in_word_t;

  typedef struct packed {
    logic [31:0]    field_value;
    lookup_status_e lookup_status;
  } out_word_t;

  // handshake between the input stage and the scan logic
  typedef struct packed {
    logic fire;
    logic last;
  } scan_ctl_t;

endpackage : hefl_pkg

`default_nettype wire

// ===== hdl/hefl_scan.sv =====
// ----------------------------------------------------------------------------
// hefl_scan: header scan state and lookup decision
// Tracks the word position, entry count and match state of the current scan
// and forms the result word for the final word of a scan.
// ----------------------------------------------------------------------------
`default_nettype none

module hefl_scan (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire  hefl_pkg::scan_ctl_t ctl_i,
  input  wire  logic [31:0]         word_i,
  input  wire  logic [31:0]         header_base_i,
  input  wire  logic [31:0]         search_key_i,
  output       hefl_pkg::out_word_t res_o
);
  import hefl_pkg::*;

  logic [PosW-1:0]  pos_q, pos_d;
  logic [EntW-1:0]  ent_q, ent_d;
  logic             pend_q, pend_d;
  logic [31:0]      held_val_q, held_val_d;
  lookup_status_e   held_st_q, held_st_d;
  logic             decided_q, decided_d;

  logic [PosW-1:0]  rel;
  logic [PosW-1:0]  idx;
  logic             in_entries;

  assign rel        = pos_q - PosW'(FirstEntryPos);
  assign idx        = rel >> 1;
  assign in_entries = (pos_q >= PosW'(FirstEntryPos)) && (pos_q < PosW'(PosLimit));

  always_comb begin
    pos_d      = pos_q;
    ent_d      = ent_q;
    pend_d     = pend_q;
    held_val_d = held_val_q;
    held_st_d  = held_st_q;
    decided_d  = decided_q;

    if (!decided_q) begin
      if (pos_q == '0) begin
        if (word_i != MagicWord) begin
          decided_d  = 1'b1;
          held_st_d  = StBadMagic;
          held_val_d = '0;
        end
      end else if (pos_q == PosW'(CountPos)) begin
        ent_d = (word_i > 32'(MaxEntries)) ? EntW'(MaxEntries) : word_i[EntW-1:0];
      end else if (in_entries) begin
        if (!rel[0]) begin
          pend_d = (PosW'(ent_q) > idx) && (word_i == search_key_i);
        end else if (pend_q) begin
          if (search_key_i[7:0] == SelValue) begin
            held_val_d = word_i;
          end else if (search_key_i[7:0] == SelAddr) begin
            held_val_d = header_base_i + (32'(pos_q) << 2);
          end else begin
            held_val_d = header_base_i + word_i;
          end
          held_st_d = StFound;
          decided_d = 1'b1;
          pend_d    = 1'b0;
        end
      end
    end

    if (pos_q < PosW'(PosLimit)) begin
      pos_d = pos_q + 1'b1;
    end
  end

  // result as seen after this word has been taken
  always_comb begin
    if (header_base_i == '0) begin
      res_o.field_value   = '0;
      res_o.lookup_status = StNullBase;
    end else if (decided_d) begin
      res_o.field_value   = (held_st_d == StFound) ? held_val_d : '0;
      res_o.lookup_status = held_st_d;
    end else begin
      res_o.field_value   = '0;
      res_o.lookup_status = StAbsent;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      ent_q      <= '0;
      pend_q     <= 1'b0;
      held_val_q <= '0;
      held_st_q  <= StAbsent;
      decided_q  <= 1'b0;
    end else if (ctl_i.fire) begin
      if (ctl_i.last) begin
        pos_q      <= '0;
        ent_q      <= '0;
        pend_q     <= 1'b0;
        held_val_q <= '0;
        held_st_q  <= StAbsent;
        decided_q  <= 1'b0;
      end else begin
        pos_q      <= pos_d;
        ent_q      <= ent_d;
        pend_q     <= pend_d;
        held_val_q <= held_val_d;
        held_st_q  <= held_st_d;
        decided_q  <= decided_d;
      end
    end
  end

  a_pos_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= PosW'(PosLimit))
    else $error("word position past limit");

  a_ent_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ent_q <= EntW'(MaxEntries))
    else $error("entry count not saturated");

  a_final_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl_i.fire && ctl_i.last |=> pos_q == '0 && !decided_q && !pend_q)
    else $error("scan state not cleared after final word");

  a_undecided_absent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !decided_q |-> held_st_q == StAbsent)
    else $error("status held without a decision");

endmodule : hefl_scan

`default_nettype wire

// ===== hdl/executable_header_field_lookup_unit.sv =====
// ----------------------------------------------------------------------------
// executable_header_field_lookup_unit: header field lookup, top level
// Scans a streamed executable header and returns the configured entry.
// ----------------------------------------------------------------------------
//   channel | dir | payload     | handshake
//   in      | in  | in_word_t   | in_valid_i / in_ready_o
//   out     | out | out_word_t  | out_valid_o / out_ready_i
//   cfg     | in  | index, data | cfg_valid_i / cfg_ready_o (always ready)
//
// One word per cycle: input register, scan logic, result register.
// A final word's result is written to the result register when the word leaves the input register.
// Only a final word waiting on a full, stalled result register holds the
// input register; other words keep flowing under output stall.
// Reset clears the scan state and both configuration registers.
// ----------------------------------------------------------------------------
`default_nettype none

module executable_header_field_lookup_unit (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       in_valid_i,
  output logic                      in_ready_o,
  input  wire  hefl_pkg::in_word_t  in_word_i,
  output logic                      out_valid_o,
  input  wire                       out_ready_i,
  output       hefl_pkg::out_word_t out_word_o,
  input  wire                       cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire  logic [hefl_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire  logic [31:0]         cfg_data_i
);
  import hefl_pkg::*;

  logic        s1_valid_q;
  in_word_t    s1_word_q;
  logic        out_valid_q;
  out_word_t   out_word_q;
  logic [31:0] header_base_q;
  logic [31:0] search_key_q;
  scan_ctl_t   ctl;
  out_word_t   res;

  assign ctl.last = s1_word_q.final_word;
  assign ctl.fire = s1_valid_q && (!s1_word_q.final_word || !out_valid_q || out_ready_i);

  assign in_ready_o  = !s1_valid_q || ctl.fire;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_word_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      header_base_q <= '0;
      search_key_q  <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgHeaderBase: header_base_q <= cfg_data_i;
        CfgSearchKey:  search_key_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      s1_word_q <= in_word_i;
    end
  end

  hefl_scan u_scan (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (ctl),
    .word_i        (s1_word_q.header_word),
    .header_base_i (header_base_q),
    .search_key_i  (search_key_q),
    .res_o         (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctl.fire && ctl.last) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl.fire && ctl.last) begin
      out_word_q <= res;
    end
  end

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=> out_valid_q && $stable(out_word_q))
    else $error("pending result word overwritten");

  a_zero_unless_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_word_q.lookup_status != StFound |-> out_word_q.field_value == '0)
    else $error("nonzero value on a miss");

  a_final_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && s1_word_q.final_word && out_valid_q && !out_ready_i |-> !in_ready_o)
    else $error("input taken while final word is stalled");

endmodule : executable_header_field_lookup_unit

`default_nettype wire

// ===== test/hefl_lookup_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// hefl_lookup_checker: predicts and checks header lookup results
// Follows the accepted words of the input and configuration channels, works
// out the lookup result of every final word and compares each accepted
// output word, field by field, with the oldest result still due.
// ----------------------------------------------------------------------------
module hefl_lookup_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic                        in_ready_i,
  input  hefl_pkg::in_word_t          in_word_i,
  input  logic                        out_valid_i,
  input  logic                        out_ready_i,
  input  hefl_pkg::out_word_t         out_word_i,
  input  logic                        cfg_valid_i,
  input  logic                        cfg_ready_i,
  input  logic [hefl_pkg::CfgIdxW-1:0] cfg_index_i,
  input  logic [31:0]                 cfg_data_i,
  output int unsigned                 fail_cnt_o,
  output int unsigned                 due_cnt_o
);
  import hefl_pkg::*;

  logic [31:0]     base_q;
  logic [31:0]     key_q;
  logic [PosW-1:0] pos_q;
  logic [EntW-1:0] ent_cnt_q;
  logic            key_hit_q;
  logic [31:0]     held_val_q;
  lookup_status_e  held_st_q;
  logic            settled_q;
  out_word_t       lookups_due[$];
  int unsigned     mismatches;

  function void clear_scan();
    pos_q      = '0;
    ent_cnt_q  = '0;
    key_hit_q  = 1'b0;
    held_val_q = '0;
    held_st_q  = StAbsent;
    settled_q  = 1'b0;
  endfunction

  function void scan_word(input logic [31:0] w, input logic last);
    int unsigned rel;
    out_word_t   res;
    if (!settled_q) begin
      if (pos_q == '0) begin
        if (w != MagicWord) begin
          settled_q  = 1'b1;
          held_st_q  = StBadMagic;
          held_val_q = '0;
        end
      end else if (pos_q == CountPos) begin
        ent_cnt_q = (w > MaxEntries) ? EntW'(MaxEntries) : EntW'(w);
      end else if (pos_q >= FirstEntryPos && pos_q < PosLimit) begin
        rel = pos_q - FirstEntryPos;
        if (!rel[0]) begin
          key_hit_q = ((rel >> 1) < ent_cnt_q) && (w == key_q);
        end else if (key_hit_q) begin
          // base is taken as it stands when the value word comes in
          case (key_q[7:0])
            SelValue: held_val_q = w;
            SelAddr:  held_val_q = base_q + {pos_q, 2'b00};
            default:  held_val_q = base_q + w;
          endcase
          held_st_q = StFound;
          settled_q = 1'b1;
          key_hit_q = 1'b0;
        end
      end
    end
    if (pos_q < PosLimit) pos_q = pos_q + 1'b1;
    if (last) begin
      if (base_q == '0) begin
        res = '{field_value: '0, lookup_status: StNullBase};
      end else if (settled_q) begin
        res = '{field_value: (held_st_q == StFound) ? held_val_q : '0,
                lookup_status: held_st_q};
      end else begin
        res = '{field_value: '0, lookup_status: StAbsent};
      end
      lookups_due.push_back(res);
      clear_scan();
    end
  endfunction

  function void flag(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%0t: %s", $time, msg);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    out_word_t exp_w;
    if (!rst_ni) begin
      base_q = '0;
      key_q  = '0;
      clear_scan();
      lookups_due.delete();
      mismatches = 0;
      fail_cnt_o <= 0;
      due_cnt_o  <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (lookups_due.size() == 0) begin
          flag($sformatf("result word with none due: value %h status %0d",
                         out_word_i.field_value, out_word_i.lookup_status));
        end else begin
          exp_w = lookups_due.pop_front();
          if (out_word_i.field_value !== exp_w.field_value ||
              out_word_i.lookup_status !== exp_w.lookup_status) begin
            flag($sformatf("result mismatch: expected value %h status %0d, got value %h status %0d",
                           exp_w.field_value, exp_w.lookup_status,
                           out_word_i.field_value, out_word_i.lookup_status));
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_reg_e'(cfg_index_i))
          CfgHeaderBase: base_q = cfg_data_i;
          CfgSearchKey:  key_q  = cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && in_ready_i) scan_word(in_word_i.header_word, in_word_i.final_word);
      fail_cnt_o <= mismatches;
      due_cnt_o  <= lookups_due.size();
    end
  end

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: regression bench for the header field lookup unit
// Streams directed and random headers (well formed, cut short, bad magic,
// noise) in random bursts, changes the lookup registers between phases and
// stalls the result side on its own patterns, with long hold-offs.
// ----------------------------------------------------------------------------
module tb_top;
  import hefl_pkg::*;

  localparam int unsigned ItemTarget   = 1450;
  localparam int unsigned CycleLimit   = 300000;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned HoldCycles   = 400;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  in_word_t           in_word;
  logic               out_valid;
  logic               out_ready;
  out_word_t          out_word;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index;
  logic [31:0]        cfg_data;

  int unsigned        fail_cnt;
  int unsigned        due_cnt;
  int unsigned        cycle_cnt = 0;
  int unsigned        words_sent = 0;
  int                 burst_left = 0;
  int                 gap_max = 0;
  int                 hold_req = 0;
  logic [31:0]        cur_key = '0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  executable_header_field_lookup_unit i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_word_i   (in_word),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_word_o  (out_word),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  hefl_lookup_checker i_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_i  (in_ready),
    .in_word_i   (in_word),
    .out_valid_i (out_valid),
    .out_ready_i (out_ready),
    .out_word_i  (out_word),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .fail_cnt_o  (fail_cnt),
    .due_cnt_o   (due_cnt)
  );

  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      2:       return 32'h8000_0000;
      3:       return 32'h0000_0001;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_base();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return 32'h0000_0001;
      3:       return 32'hFFFF_FFF0;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] pick_key();
    logic [31:0] k;
    k = $urandom;
    case ($urandom_range(0, 5))
      0, 1: k[7:0] = SelValue;
      2, 3: k[7:0] = SelAddr;
      4:    k = ($urandom_range(0, 1) != 0) ? '1 : '0;
      default: ;
    endcase
    return k;
  endfunction

  // one input word; a burst ends with a random gap before the next word
  task automatic push_word(input logic [31:0] w, input logic last);
    int gap;
    if (burst_left <= 0) begin
      gap = (gap_max > 0) ? $urandom_range(0, gap_max) : 0;
      burst_left = $urandom_range(1, 32);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_word  <= '{header_word: w, final_word: last};
    do @(posedge clk); while (!in_ready);
    burst_left--;
    words_sent++;
  endtask

  // an open header stops halfway without its final word
  task automatic send_hdr(input logic [31:0] hdr[$], input bit close);
    int last_i;
    last_i = close ? hdr.size() - 1 : (hdr.size() + 1) / 2 - 1;
    for (int i = 0; i <= last_i; i++) push_word(hdr[i], close && i == last_i);
  endtask

  task automatic send_scan(input bit close);
    logic [31:0] hdr[$];
    logic [31:0] count;
    int          n_ent;
    int          kind;
    int          keep;
    kind = $urandom_range(0, 99);
    if (kind < 12) begin
      repeat ($urandom_range(1, 6)) hdr.push_back(($urandom_range(0, 3) == 0) ? cur_key : rand_word());
      if ($urandom_range(0, 1) != 0) hdr[0] = MagicWord;
    end else begin
      n_ent = $urandom_range(0, 5);
      case ($urandom_range(0, 7))
        0:       count = '1;
        1:       count = MaxEntries + $urandom_range(0, 2);
        2:       count = (n_ent > 0) ? n_ent - 1 : 0;
        3:       count = $urandom;
        default: count = n_ent;
      endcase
      hdr.push_back(MagicWord);
      repeat (4) hdr.push_back(rand_word());
      hdr.push_back(count);
      repeat (n_ent) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: hdr.push_back(cur_key);
          4:          hdr.push_back(cur_key ^ (32'h1 << $urandom_range(0, 31)));
          default:    hdr.push_back(rand_word());
        endcase
        hdr.push_back(rand_word());
      end
      // cut short: keep a random leading part of the header, possibly all of it
      if (kind < 25) begin
        keep = $urandom_range(1, hdr.size());
        while (hdr.size() > keep) void'(hdr.pop_back());
      end
    end
    send_hdr(hdr, close);
  endtask

  // full table, saturated count, match on the last entry, then words past the end
  task automatic send_long_scan();
    logic [31:0] hdr[$];
    hdr.push_back(MagicWord);
    repeat (4) hdr.push_back(rand_word());
    hdr.push_back('1);
    for (int i = 0; i < MaxEntries; i++) begin
      hdr.push_back((i == MaxEntries - 1) ? cur_key : cur_key ^ 32'h100);
      hdr.push_back(rand_word());
    end
    repeat (2) begin
      hdr.push_back(cur_key);
      hdr.push_back(rand_word());
    end
    send_hdr(hdr, 1'b1);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (due_cnt != 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic set_regs(input bit [1:0] wr, input logic [31:0] base, input logic [31:0] key);
    for (int r = 0; r < 2; r++) begin
      if (wr[r]) begin
        cfg_valid <= 1'b1;
        cfg_index <= (r == 0) ? CfgHeaderBase : CfgSearchKey;
        cfg_data  <= (r == 0) ? base : key;
        do @(posedge clk); while (!cfg_ready);
      end
    end
    cfg_valid <= 1'b0;
    if (wr[1]) cur_key = key;
  endtask

  initial begin : rx_side
    int         mode;
    int         mode_left;
    int         hold_seen;
    logic [7:0] stall_pat;
    mode      = 0;
    mode_left = 0;
    hold_seen = 0;
    stall_pat = 8'hA5;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_seen != hold_req) begin
        // long hold-off: the block fills up and backs up its input
        out_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
        hold_seen = hold_req;
      end else begin
        if (mode_left <= 0) begin
          mode      = $urandom_range(0, 3);
          mode_left = $urandom_range(20, 200);
          stall_pat = 8'($urandom) | 8'h01;
        end
        mode_left--;
        case (mode)
          0: out_ready <= 1'b1;
          1: out_ready <= ($urandom_range(0, 3) != 0);
          2: begin
            out_ready <= stall_pat[0];
            stall_pat = {stall_pat[0], stall_pat[7:1]};
          end
          default: out_ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  initial begin : watchdog
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("executable_header_field_lookup_unit regression: fail");
    $finish;
  end

  initial begin : stimulus
    logic [31:0] hdr[$];
    logic [31:0] base_pick;
    logic [31:0] key_pick;
    int          phase;
    int unsigned phase_end;
    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_word   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= CfgHeaderBase;
    cfg_data  <= '0;
    gap_max = 3;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // registers still at reset: null base wins
    hdr = {32'h0000_0000};
    send_hdr(hdr, 1'b1);
    drain();
    set_regs(2'b11, 32'hFFFF_FFF0, 32'h0000_0000);
    // saturated count, value select
    hdr = {MagicWord, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF,
           32'h0000_0000, 32'hFFFF_FFFF};
    send_hdr(hdr, 1'b1);
    hdr = {32'hFFFF_FFFF};
    send_hdr(hdr, 1'b1);
    hdr = {MagicWord};
    send_hdr(hdr, 1'b1);
    drain();
    set_regs(2'b10, 32'h0, 32'hFFFF_FF01);
    // matching key past the declared count
    hdr = {MagicWord, 32'h1, 32'h2, 32'h3, 32'h4, 32'h0, 32'hFFFF_FF01, 32'h7};
    send_hdr(hdr, 1'b1);
    // address select, wraps past the top
    hdr = {MagicWord, 32'h0, 32'h0, 32'h0, 32'h0, 32'h2, 32'h5, 32'h6, 32'hFFFF_FF01, 32'h9};
    send_hdr(hdr, 1'b1);
    drain();
    set_regs(2'b10, 32'h0, 32'h8000_0042);
    hdr = {MagicWord, 32'h0, 32'h0, 32'h0, 32'h0, 32'h1, 32'h8000_0042, 32'h20};
    send_hdr(hdr, 1'b1);

    phase = 0;
    while (words_sent < ItemTarget) begin
      drain();
      base_pick = pick_base();
      key_pick  = pick_key();
      if (phase == 2) begin
        base_pick = 32'hFFFF_F000;
        key_pick[7:0] = SelAddr;
      end
      set_regs((phase == 0) ? 2'b11 : 2'($urandom_range(1, 3)), base_pick, key_pick);
      case (phase % 3)
        0:       gap_max = 0;
        1:       gap_max = 4;
        default: gap_max = 12;
      endcase
      if (phase == 1 || phase == 4) hold_req++;
      if (phase == 2) send_long_scan();
      phase_end = words_sent + $urandom_range(100, 200);
      while (words_sent < phase_end && words_sent < ItemTarget) send_scan(1'b1);
      // leave a header open across the next register write
      if ($urandom_range(0, 3) == 0) send_scan(1'b0);
      phase++;
    end
    send_scan(1'b1);
    drain();

    if (fail_cnt == 0 && due_cnt == 0) begin
      $display("executable_header_field_lookup_unit regression: pass");
    end else begin
      $display("executable_header_field_lookup_unit regression: fail");
    end
    $finish;
  end

endmodule
